@@ sv/scc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types, constants and calendar tables for the seconds counter
// calendar converter.
// ----------------------------------------------------------------------------
package scc_pkg;

    typedef enum logic [2:0] {
        KIND_READ    = 3'd0,
        KIND_YEAR    = 3'd1,
        KIND_MONTH   = 3'd2,
        KIND_DAY     = 3'd3,
        KIND_WEEKDAY = 3'd4,
        KIND_HOUR    = 3'd5,
        KIND_MINUTE  = 3'd6,
        KIND_SECOND  = 3'd7
    } kind_t;

    localparam logic [31:0] CENTURY_SECS   = 32'd3155760000;
    localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
    localparam logic [10:0] DAYS_PER_CYCLE = 11'd1461;
    // floor(2^32 / 675), counter is pre-shifted by 7
    localparam logic [22:0] DAY_RECIP      = 23'd6362914;
    // floor(2^24 / 1461)
    localparam logic [13:0] CYCLE_RECIP    = 14'd11483;
    // floor(2^24 / 3600)
    localparam logic [12:0] HOUR_RECIP     = 13'd4660;
    // floor(2^24 / 60)
    localparam logic [18:0] MIN_RECIP      = 19'd279620;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  value;
        logic [31:0] counter;
    } req_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  value;
        logic [31:0] counter;
        logic [15:0] days;
        logic [16:0] tod;
    } split_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  value;
        logic [31:0] counter;
        logic [15:0] days;
        logic [6:0]  year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } cal_t;

    typedef struct packed {
        logic [31:0] new_counter;
        logic        accepted;
        logic [6:0]  year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [2:0]  weekday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } result_t;

    // days before the first of a month, non-leap year, month 1..12
    function automatic logic [8:0] month_start(input logic [3:0] month);
        logic [8:0] d;
        unique case (month)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // last day of a month, leap when the two low year bits are zero
    function automatic logic [4:0] last_day(input logic [1:0] year_lsbs,
                                            input logic [3:0] month);
        logic [4:0] n;
        unique case (month) inside
            4'd2:                    n = (year_lsbs == 2'd0) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
            default:                 n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

@@ sv/seconds_counter_calendar_convert_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seconds_counter_calendar_convert_top
// Seconds counter to calendar converter with field set and recompose.
// ----------------------------------------------------------------------------
// usage
//   slave channel: one transaction per access, tuser = operation kind
//   (read, or set year, month, day, weekday, hour, minute, second),
//   tdata = current seconds count and the new field value
//   master channel: one transaction per access with the resulting count,
//   the accepted flag and the decoded calendar fields of that count
//   pipeline: ten register stages from acceptance to tvalid
//   (3 day split, 4 calendar decode, 3 check and recompose)
//   throughput: one transaction per cycle while the master side takes results
//   stall: a stage holds while the one after it is full and held; empty
//   stages keep filling, so the slave side stays ready until the pipe fills
//   reset: all stage valid bits clear, no transaction is in flight
// ----------------------------------------------------------------------------
module seconds_counter_calendar_convert_top
    import scc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // counter[31:0], value[39:32]
    input  logic [2:0]  s_axis_tuser,   // kind[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata    // new_counter, accepted, year, month,
                                        // day_of_month, weekday, hour, minute,
                                        // second, zero fill
);

    req_t    req;
    split_t  split_data;
    cal_t    cal_data;
    result_t res;

    logic    split_valid;
    logic    split_ready;
    logic    cal_valid;
    logic    cal_ready;

    assign req.kind    = kind_t'(s_axis_tuser);
    assign req.counter = s_axis_tdata[31:0];
    assign req.value   = s_axis_tdata[39:32];

    scc_split u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (req),
        .out_valid (split_valid),
        .out_ready (split_ready),
        .out_data  (split_data)
    );

    scc_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (split_valid),
        .in_ready  (split_ready),
        .in_data   (split_data),
        .out_valid (cal_valid),
        .out_ready (cal_ready),
        .out_data  (cal_data)
    );

    scc_compose u_compose (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cal_valid),
        .in_ready  (cal_ready),
        .in_data   (cal_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res)
    );

    assign m_axis_tdata = {3'b000, res.second, res.minute, res.hour, res.weekday,
                           res.day_of_month, res.month, res.year, res.accepted,
                           res.new_counter};

endmodule

@@ sv/scc_split.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_split
// Three-stage split of the seconds count into whole days and time of day,
// using a reciprocal multiply and a single correction step.
// ----------------------------------------------------------------------------
module scc_split
    import scc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  req_t   in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output split_t out_data
);

    typedef struct packed {
        req_t        req;
        logic [15:0] day_est;
    } est_t;

    logic [2:0]  valid_reg;
    logic [2:0]  adv;

    req_t        s1_reg, s1_next;
    est_t        s2_reg, s2_next;
    split_t      s3_reg, s3_next;

    logic [47:0] day_prod;
    logic [32:0] day_back;
    logic [17:0] day_rem;

    assign adv[2]   = !valid_reg[2] || out_ready;
    assign adv[1]   = !valid_reg[1] || adv[2];
    assign adv[0]   = !valid_reg[0] || adv[1];
    assign in_ready = adv[0];

    // century wrap
    always_comb
    begin
        s1_next = in_data;
        if (in_data.counter >= CENTURY_SECS)
        begin
            s1_next.counter = in_data.counter - CENTURY_SECS;
        end
    end

    // day estimate, may be one low
    assign day_prod = 48'(s1_reg.counter[31:7]) * 48'(DAY_RECIP);

    always_comb
    begin
        s2_next.req     = s1_reg;
        s2_next.day_est = day_prod[47:32];
    end

    // correction
    assign day_back = 33'(s2_reg.day_est) * 33'(SECS_PER_DAY);
    assign day_rem  = 18'(s2_reg.req.counter - day_back[31:0]);

    always_comb
    begin
        s3_next.kind    = s2_reg.req.kind;
        s3_next.value   = s2_reg.req.value;
        s3_next.counter = s2_reg.req.counter;
        if (day_rem >= 18'(SECS_PER_DAY))
        begin
            s3_next.days = s2_reg.day_est + 16'd1;
            s3_next.tod  = 17'(day_rem - 18'(SECS_PER_DAY));
        end
        else
        begin
            s3_next.days = s2_reg.day_est;
            s3_next.tod  = day_rem[16:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            if (adv[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
            if (adv[2])
            begin
                valid_reg[2] <= valid_reg[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_reg <= s1_next;
        end
        if (adv[1])
        begin
            s2_reg <= s2_next;
        end
        if (adv[2])
        begin
            s3_reg <= s3_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_data  = s3_reg;

endmodule

@@ sv/scc_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_decode
// Four-stage decode of days and time of day into year, month, day of
// month, hour, minute and second.
// ----------------------------------------------------------------------------
module scc_decode
    import scc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  split_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output cal_t   out_data
);

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  value;
        logic [31:0] counter;
        logic [15:0] days;
    } base_t;

    typedef struct packed {
        base_t       base;
        logic [16:0] tod;
        logic [4:0]  hour_est;
        logic [10:0] min_est;
        logic [4:0]  cyc_est;
    } est_t;

    typedef struct packed {
        base_t       base;
        logic [4:0]  hour;
        logic [10:0] tot_min;
        logic [5:0]  second;
        logic [4:0]  cyc;
        logic [10:0] cyc_day;
    } div_t;

    typedef struct packed {
        base_t       base;
        logic [6:0]  year;
        logic        leap;
        logic [8:0]  doy;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } ymd_t;

    logic [3:0]  valid_reg;
    logic [3:0]  adv;

    est_t        s4_reg, s4_next;
    div_t        s5_reg, s5_next;
    ymd_t        s6_reg, s6_next;
    cal_t        s7_reg, s7_next;

    logic [29:0] hour_prod;
    logic [35:0] min_prod;
    logic [29:0] cyc_prod;
    logic [16:0] hour_rem;
    logic [16:0] min_rem;
    logic [15:0] cyc_rem;
    logic [10:0] min_back;
    logic [10:0] yr_rem;

    assign adv[3]   = !valid_reg[3] || out_ready;
    assign adv[2]   = !valid_reg[2] || adv[3];
    assign adv[1]   = !valid_reg[1] || adv[2];
    assign adv[0]   = !valid_reg[0] || adv[1];
    assign in_ready = adv[0];

    // quotient estimates
    assign hour_prod = 30'(in_data.tod) * 30'(HOUR_RECIP);
    assign min_prod  = 36'(in_data.tod) * 36'(MIN_RECIP);
    assign cyc_prod  = 30'(in_data.days) * 30'(CYCLE_RECIP);

    always_comb
    begin
        s4_next.base.kind    = in_data.kind;
        s4_next.base.value   = in_data.value;
        s4_next.base.counter = in_data.counter;
        s4_next.base.days    = in_data.days;
        s4_next.tod          = in_data.tod;
        s4_next.hour_est     = hour_prod[28:24];
        s4_next.min_est      = min_prod[34:24];
        s4_next.cyc_est      = cyc_prod[28:24];
    end

    // quotient corrections
    assign hour_rem = s4_reg.tod - 17'(s4_reg.hour_est) * 17'd3600;
    assign min_rem  = s4_reg.tod - 17'(s4_reg.min_est) * 17'd60;
    assign cyc_rem  = s4_reg.base.days - 16'(s4_reg.cyc_est) * 16'(DAYS_PER_CYCLE);

    always_comb
    begin
        s5_next.base = s4_reg.base;
        if (hour_rem >= 17'd3600)
        begin
            s5_next.hour = s4_reg.hour_est + 5'd1;
        end
        else
        begin
            s5_next.hour = s4_reg.hour_est;
        end
        if (min_rem >= 17'd60)
        begin
            s5_next.tot_min = s4_reg.min_est + 11'd1;
            s5_next.second  = 6'(min_rem - 17'd60);
        end
        else
        begin
            s5_next.tot_min = s4_reg.min_est;
            s5_next.second  = min_rem[5:0];
        end
        if (cyc_rem >= 16'(DAYS_PER_CYCLE))
        begin
            s5_next.cyc     = s4_reg.cyc_est + 5'd1;
            s5_next.cyc_day = 11'(cyc_rem - 16'(DAYS_PER_CYCLE));
        end
        else
        begin
            s5_next.cyc     = s4_reg.cyc_est;
            s5_next.cyc_day = cyc_rem[10:0];
        end
    end

    // year in cycle, minute
    assign min_back = 11'(s5_reg.hour) * 11'd60;
    assign yr_rem   = s5_reg.cyc_day - 11'd366;

    always_comb
    begin
        logic [1:0] yic;
        logic [8:0] doy;
        if (s5_reg.cyc_day < 11'd366)
        begin
            yic = 2'd0;
            doy = s5_reg.cyc_day[8:0];
        end
        else if (yr_rem < 11'd365)
        begin
            yic = 2'd1;
            doy = yr_rem[8:0];
        end
        else if (yr_rem < 11'd730)
        begin
            yic = 2'd2;
            doy = 9'(yr_rem - 11'd365);
        end
        else
        begin
            yic = 2'd3;
            doy = 9'(yr_rem - 11'd730);
        end
        s6_next.base   = s5_reg.base;
        s6_next.year   = {s5_reg.cyc, 2'b00} + 7'(yic);
        s6_next.leap   = (yic == 2'd0);
        s6_next.doy    = doy;
        s6_next.hour   = s5_reg.hour;
        s6_next.minute = 6'(s5_reg.tot_min - min_back);
        s6_next.second = s5_reg.second;
    end

    // month and day of month
    always_comb
    begin
        logic [3:0] mon;
        logic [8:0] thr;
        logic [8:0] extra;
        mon = 4'd1;
        for (int i = 2; i <= 12; i++)
        begin
            thr = month_start(4'(i)) + ((s6_reg.leap && i >= 3) ? 9'd1 : 9'd0);
            if (s6_reg.doy >= thr)
            begin
                mon = 4'(i);
            end
        end
        extra = (s6_reg.leap && mon >= 4'd3) ? 9'd1 : 9'd0;
        s7_next.kind    = s6_reg.base.kind;
        s7_next.value   = s6_reg.base.value;
        s7_next.counter = s6_reg.base.counter;
        s7_next.days    = s6_reg.base.days;
        s7_next.year    = s6_reg.year;
        s7_next.month   = mon;
        s7_next.mday    = 5'(s6_reg.doy - month_start(mon) - extra + 9'd1);
        s7_next.hour    = s6_reg.hour;
        s7_next.minute  = s6_reg.minute;
        s7_next.second  = s6_reg.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            if (adv[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
            if (adv[2])
            begin
                valid_reg[2] <= valid_reg[1];
            end
            if (adv[3])
            begin
                valid_reg[3] <= valid_reg[2];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s4_reg <= s4_next;
        end
        if (adv[1])
        begin
            s5_reg <= s5_next;
        end
        if (adv[2])
        begin
            s6_reg <= s6_next;
        end
        if (adv[3])
        begin
            s7_reg <= s7_next;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_data  = s7_reg;

endmodule

@@ sv/scc_compose.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_compose
// Three-stage set and range check, recomposition of the seconds count
// and weekday, ending in the output register.
// ----------------------------------------------------------------------------
module scc_compose
    import scc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  cal_t    in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    typedef struct packed {
        logic [6:0]  year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } fields_t;

    typedef struct packed {
        kind_t       kind;
        logic        ok;
        logic        apply;
        logic [31:0] counter;
        logic [15:0] days;
        fields_t     f;
    } chk_t;

    typedef struct packed {
        logic        ok;
        logic        apply;
        logic [31:0] counter;
        logic [15:0] days;
        logic [16:0] tod;
        fields_t     f;
    } sum_t;

    logic [2:0]  valid_reg;
    logic [2:0]  adv;

    chk_t        s8_reg, s8_next;
    sum_t        s9_reg, s9_next;
    result_t     s10_reg, s10_next;

    logic [4:0]  ld_cur;
    logic [4:0]  ld_year;
    logic [4:0]  ld_month;
    logic [31:0] c_new;
    logic [17:0] wd_x;
    logic [5:0]  wd_sum;
    logic [3:0]  wd_fold;

    assign adv[2]   = !valid_reg[2] || out_ready;
    assign adv[1]   = !valid_reg[1] || adv[2];
    assign adv[0]   = !valid_reg[0] || adv[1];
    assign in_ready = adv[0];

    // field replace and range check
    assign ld_cur   = last_day(in_data.year[1:0], in_data.month);
    assign ld_year  = last_day(in_data.value[1:0], in_data.month);
    assign ld_month = last_day(in_data.year[1:0], in_data.value[3:0]);

    always_comb
    begin
        fields_t t;
        fields_t n;
        logic    ok;
        t.year   = in_data.year;
        t.month  = in_data.month;
        t.mday   = in_data.mday;
        t.hour   = in_data.hour;
        t.minute = in_data.minute;
        t.second = in_data.second;
        n        = t;
        ok       = 1'b1;
        case (in_data.kind)
            KIND_READ:
            begin
                ok = 1'b1;
            end
            KIND_YEAR:
            begin
                n.year = in_data.value[6:0];
                ok     = (in_data.value <= 8'd99) && (in_data.mday <= ld_year);
            end
            KIND_MONTH:
            begin
                n.month = in_data.value[3:0];
                ok      = (in_data.value >= 8'd1) && (in_data.value <= 8'd12)
                          && (in_data.mday <= ld_month);
            end
            KIND_DAY:
            begin
                n.mday = in_data.value[4:0];
                ok     = (in_data.value >= 8'd1) && (in_data.value <= 8'(ld_cur));
            end
            KIND_WEEKDAY:
            begin
                ok = 1'b0;
            end
            KIND_HOUR:
            begin
                n.hour = in_data.value[4:0];
                ok     = (in_data.value <= 8'd23);
            end
            KIND_MINUTE:
            begin
                n.minute = in_data.value[5:0];
                ok       = (in_data.value <= 8'd59);
            end
            KIND_SECOND:
            begin
                n.second = in_data.value[5:0];
                ok       = (in_data.value <= 8'd59);
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
        s8_next.kind    = in_data.kind;
        s8_next.ok      = ok;
        s8_next.apply   = ok && (in_data.kind != KIND_READ);
        s8_next.counter = in_data.counter;
        s8_next.days    = in_data.days;
        s8_next.f       = s8_next.apply ? n : t;
    end

    // day number and time of day of the new fields
    always_comb
    begin
        logic [15:0] days_n;
        logic [15:0] leap_adj;
        leap_adj = ((s8_reg.f.year[1:0] == 2'd0) && (s8_reg.f.month > 4'd2))
                   ? 16'd1 : 16'd0;
        days_n = 16'(s8_reg.f.year) * 16'd365
               + 16'((8'(s8_reg.f.year) + 8'd3) >> 2)
               + 16'(month_start(s8_reg.f.month))
               + 16'(s8_reg.f.mday) - 16'd1 + leap_adj;
        s9_next.ok      = s8_reg.ok;
        s9_next.apply   = s8_reg.apply;
        s9_next.counter = s8_reg.counter;
        s9_next.days    = s8_reg.apply ? days_n : s8_reg.days;
        s9_next.tod     = 17'(s8_reg.f.hour) * 17'd3600
                        + 17'(s8_reg.f.minute) * 17'd60
                        + 17'(s8_reg.f.second);
        s9_next.f       = s8_reg.f;
    end

    // recomposed count, weekday by folding base-8 digits mod 7
    assign c_new   = 32'(s9_reg.days) * 32'(SECS_PER_DAY) + 32'(s9_reg.tod);
    assign wd_x    = 18'(s9_reg.days) + 18'd5;
    assign wd_sum  = 6'(wd_x[2:0]) + 6'(wd_x[5:3]) + 6'(wd_x[8:6])
                   + 6'(wd_x[11:9]) + 6'(wd_x[14:12]) + 6'(wd_x[17:15]);
    assign wd_fold = 4'(wd_sum[5:3]) + 4'(wd_sum[2:0]);

    always_comb
    begin
        logic [3:0] wd_mod;
        if (wd_fold >= 4'd14)
        begin
            wd_mod = 4'd0;
        end
        else if (wd_fold >= 4'd7)
        begin
            wd_mod = wd_fold - 4'd7;
        end
        else
        begin
            wd_mod = wd_fold;
        end
        s10_next.new_counter  = s9_reg.apply ? c_new : s9_reg.counter;
        s10_next.accepted     = s9_reg.ok;
        s10_next.year         = s9_reg.f.year;
        s10_next.month        = s9_reg.f.month;
        s10_next.day_of_month = s9_reg.f.mday;
        s10_next.weekday      = 3'(wd_mod) + 3'd1;
        s10_next.hour         = s9_reg.f.hour;
        s10_next.minute       = s9_reg.f.minute;
        s10_next.second       = s9_reg.f.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            if (adv[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
            if (adv[2])
            begin
                valid_reg[2] <= valid_reg[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s8_reg <= s8_next;
        end
        if (adv[1])
        begin
            s9_reg <= s9_next;
        end
        if (adv[2])
        begin
            s10_reg <= s10_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_data  = s10_reg;

`ifndef SYNTHESIS
    // rejected or read transaction keeps its count
    assert property (@(posedge clk) disable iff (!rst_n)
        adv[2] && valid_reg[1] && !s9_reg.apply
        |=> out_data.new_counter == $past(s9_reg.counter))
        else $error("count changed without applied set");

    // weekday set never goes through
    assert property (@(posedge clk) disable iff (!rst_n)
        adv[1] && valid_reg[0] && s8_reg.kind == KIND_WEEKDAY
        |=> !s9_reg.ok)
        else $error("weekday set accepted");

    // decoded month, day and weekday stay in range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.month != 4'd0 && out_data.month <= 4'd12
                      && out_data.day_of_month != 5'd0 && out_data.weekday != 3'd0)
        else $error("calendar field out of range");

    // output count stays within the century
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.new_counter < CENTURY_SECS)
        else $error("count past century");
`endif

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the seconds counter calendar converter. A driver
// feeds accesses (reads and single-field sets) from a queue, an independent
// calendar predictor computes the expected count, accept flag and decoded
// fields, and a monitor compares every result transaction in order. Both
// stream sides idle and stall at random, with stretches of full rate.
// ----------------------------------------------------------------------------
module tb_top;
    import scc_pkg::*;

    localparam int unsigned DAY_SECS     = 86400;
    localparam int unsigned CYCLE_DAYS   = 1461;
    localparam int unsigned CENTURY      = 32'd3155760000;
    localparam int unsigned RANDOM_ITEMS = 1425;

    typedef struct {
        kind_t       kind;
        logic [31:0] counter;
        logic [7:0]  value;
        int unsigned gap_after;
        bit          drain_first;
    } access_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;       // counter[31:0], value[39:32]
    logic [2:0]  s_axis_tuser = KIND_READ; // kind[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;            // new_counter, accepted, year, month,
                                          // day_of_month, weekday, hour, minute,
                                          // second, zero fill

    access_t     pending_accesses[$];
    result_t     expected_results[$];
    access_t     on_bus;
    int unsigned idle_left = 0;
    int unsigned stall_left = 0;
    int unsigned sent_count = 0;
    int unsigned result_count = 0;
    int unsigned applied_count = 0;
    int unsigned rejected_count = 0;
    int unsigned wrapped_count = 0;
    int unsigned error_count = 0;

    seconds_counter_calendar_convert_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 clk = ~clk;

    // days before the first of a month, leap adds february 29
    function automatic int unsigned day_count_before(int unsigned mon, bit leap);
        int unsigned d;
        case (mon)
            1:       d = 0;
            2:       d = 31;
            3:       d = 59;
            4:       d = 90;
            5:       d = 120;
            6:       d = 151;
            7:       d = 181;
            8:       d = 212;
            9:       d = 243;
            10:      d = 273;
            11:      d = 304;
            default: d = 334;
        endcase
        if (leap && mon > 2)
            d = d + 1;
        return d;
    endfunction

    function automatic int unsigned month_length(int unsigned yr, int unsigned mon);
        int unsigned n;
        case (mon)
            2:             n = (yr % 4 == 0) ? 29 : 28;
            4, 6, 9, 11:   n = 30;
            default:       n = 31;
        endcase
        return n;
    endfunction

    function automatic result_t convert_counter(kind_t kind, logic [31:0] count_in,
                                                logic [7:0] value);
        int unsigned count, days, tod, rem, yic, doy;
        int unsigned yr, mon, md, hr, mi, se;
        int unsigned v;
        bit          leap;
        bit          ok;
        result_t     res;
        count = count_in;
        v = value;
        if (count >= CENTURY)
            count = count - CENTURY;
        days = count / DAY_SECS;
        tod = count % DAY_SECS;
        rem = days % CYCLE_DAYS;
        if (rem < 366)
        begin
            yic = 0;
            doy = rem;
        end
        else
        begin
            yic = 1 + (rem - 366) / 365;
            doy = (rem - 366) % 365;
        end
        yr = (days / CYCLE_DAYS) * 4 + yic;
        leap = (yic == 0);
        mon = 12;
        while (mon > 1 && doy < day_count_before(mon, leap))
            mon = mon - 1;
        md = doy - day_count_before(mon, leap) + 1;
        hr = tod / 3600;
        mi = (tod / 60) % 60;
        se = tod % 60;
        ok = 1'b1;
        case (kind)
            KIND_READ: ;
            KIND_YEAR:
            begin
                ok = (v <= 99) && (md <= month_length(v, mon));
                if (ok)
                    yr = v;
            end
            KIND_MONTH:
            begin
                ok = (v >= 1 && v <= 12) && (md <= month_length(yr, v));
                if (ok)
                    mon = v;
            end
            KIND_DAY:
            begin
                ok = (v >= 1 && v <= month_length(yr, mon));
                if (ok)
                    md = v;
            end
            KIND_WEEKDAY: ok = 1'b0;
            KIND_HOUR:
            begin
                ok = (v <= 23);
                if (ok)
                    hr = v;
            end
            KIND_MINUTE:
            begin
                ok = (v <= 59);
                if (ok)
                    mi = v;
            end
            default:
            begin
                ok = (v <= 59);
                if (ok)
                    se = v;
            end
        endcase
        if (ok && kind != KIND_READ)
        begin
            days = yr * 365 + (yr + 3) / 4 + day_count_before(mon, yr % 4 == 0) + md - 1;
            count = days * DAY_SECS + hr * 3600 + mi * 60 + se;
        end
        res.new_counter  = count;
        res.accepted     = ok;
        res.year         = yr[6:0];
        res.month        = mon[3:0];
        res.day_of_month = md[4:0];
        res.weekday      = 3'(((count / DAY_SECS) + 5) % 7 + 1);
        res.hour         = hr[4:0];
        res.minute       = mi[5:0];
        res.second       = se[5:0];
        return res;
    endfunction

    task automatic push_access(kind_t kind, logic [31:0] counter, logic [7:0] value,
                               int unsigned gap, bit drain);
        access_t a;
        a.kind = kind;
        a.counter = counter;
        a.value = value;
        a.gap_after = gap;
        a.drain_first = drain;
        pending_accesses.push_back(a);
    endtask

    task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected %0d actual %0d", name, exp_val, act_val);
            error_count++;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        bit      fire;
        result_t exp_res;
        access_t a;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= KIND_READ;
        end
        else
        begin
            fire = s_axis_tvalid && s_axis_tready;
            if (fire)
            begin
                exp_res = convert_counter(on_bus.kind, on_bus.counter, on_bus.value);
                expected_results.push_back(exp_res);
                sent_count++;
                if (on_bus.counter >= CENTURY)
                    wrapped_count++;
                if (on_bus.kind != KIND_READ)
                begin
                    if (exp_res.accepted)
                        applied_count++;
                    else
                        rejected_count++;
                end
            end
            if (!(s_axis_tvalid && !fire))
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_accesses.size() > 0 &&
                         (!pending_accesses[0].drain_first ||
                          expected_results.size() == 0))
                begin
                    a = pending_accesses.pop_front();
                    on_bus = a;
                    idle_left = a.gap_after;
                    s_axis_tdata  <= {a.value, a.counter};
                    s_axis_tuser  <= a.kind;
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_res;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                result_count++;
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with no access outstanding");
                    error_count++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    check_field("new_counter", exp_res.new_counter, m_axis_tdata[31:0]);
                    check_field("accepted", exp_res.accepted, m_axis_tdata[32]);
                    check_field("year", exp_res.year, m_axis_tdata[39:33]);
                    check_field("month", exp_res.month, m_axis_tdata[43:40]);
                    check_field("day_of_month", exp_res.day_of_month, m_axis_tdata[48:44]);
                    check_field("weekday", exp_res.weekday, m_axis_tdata[51:49]);
                    check_field("hour", exp_res.hour, m_axis_tdata[56:52]);
                    check_field("minute", exp_res.minute, m_axis_tdata[62:57]);
                    check_field("second", exp_res.second, m_axis_tdata[68:63]);
                end
                stall_left = (result_count % 400 < 120) ? 0 : $urandom_range(0, 5);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        #400000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        kind_t       k;
        logic [31:0] c;
        logic [7:0]  v;
        int unsigned sel;
        int unsigned gap;
        int unsigned total_items;
        // directed: extremes of the count, every kind, range edges
        push_access(KIND_READ, 32'd0, 8'd0, $urandom_range(0, 5), 1'b0);
        push_access(KIND_READ, CENTURY - 1, 8'hFF, $urandom_range(0, 5), 1'b0);
        push_access(KIND_READ, CENTURY, 8'd0, $urandom_range(0, 5), 1'b0);
        push_access(KIND_READ, 32'hFFFF_FFFF, 8'hA5, $urandom_range(0, 5), 1'b0);
        push_access(KIND_YEAR, 32'd0, 8'd99, $urandom_range(0, 5), 1'b0);
        push_access(KIND_YEAR, 32'd0, 8'd100, $urandom_range(0, 5), 1'b0);
        push_access(KIND_YEAR, 32'd0, 8'd255, $urandom_range(0, 5), 1'b0);
        // february 29 moved to a common year, then to a leap year
        push_access(KIND_YEAR, 32'd5097600, 8'd1, $urandom_range(0, 5), 1'b0);
        push_access(KIND_YEAR, 32'd5097600, 8'd4, $urandom_range(0, 5), 1'b0);
        push_access(KIND_MONTH, 32'd0, 8'd0, $urandom_range(0, 5), 1'b0);
        push_access(KIND_MONTH, 32'd0, 8'd13, $urandom_range(0, 5), 1'b0);
        push_access(KIND_MONTH, 32'd0, 8'd12, $urandom_range(0, 5), 1'b0);
        // january 31 moved to february
        push_access(KIND_MONTH, 32'd2592000, 8'd2, $urandom_range(0, 5), 1'b0);
        push_access(KIND_DAY, 32'd7862400, 8'd0, $urandom_range(0, 5), 1'b0);
        push_access(KIND_DAY, 32'd7862400, 8'd31, $urandom_range(0, 5), 1'b0);
        push_access(KIND_DAY, 32'd7862400, 8'd30, $urandom_range(0, 5), 1'b0);
        push_access(KIND_DAY, 32'd34300800, 8'd29, $urandom_range(0, 5), 1'b0);
        push_access(KIND_WEEKDAY, 32'd86400, 8'd1, $urandom_range(0, 5), 1'b0);
        push_access(KIND_HOUR, 32'd0, 8'd23, $urandom_range(0, 5), 1'b0);
        push_access(KIND_HOUR, 32'd0, 8'd24, $urandom_range(0, 5), 1'b0);
        push_access(KIND_MINUTE, 32'd0, 8'd59, $urandom_range(0, 5), 1'b0);
        push_access(KIND_MINUTE, 32'd0, 8'd60, $urandom_range(0, 5), 1'b0);
        push_access(KIND_SECOND, CENTURY - 1, 8'd0, $urandom_range(0, 5), 1'b0);
        push_access(KIND_SECOND, 32'd0, 8'd60, 0, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
                c = $urandom;
            else if (sel == 1)
                c = CENTURY - 1 - $urandom_range(0, 200000);
            else if (sel == 2)
                c = 32'd5097600 + CYCLE_DAYS * DAY_SECS * $urandom_range(0, 24)
                    + $urandom_range(0, 2 * DAY_SECS);
            else
                c = $urandom_range(0, CENTURY - 1);
            k = kind_t'($urandom_range(0, 7));
            if ($urandom_range(0, 4) == 0)
            begin
                v = $urandom_range(0, 255);
            end
            else
            begin
                case (k)
                    KIND_YEAR:   v = $urandom_range(0, 99);
                    KIND_MONTH:  v = $urandom_range(1, 12);
                    KIND_DAY:    v = $urandom_range(1, 31);
                    KIND_HOUR:   v = $urandom_range(0, 23);
                    KIND_MINUTE: v = $urandom_range(0, 59);
                    KIND_SECOND: v = $urandom_range(0, 59);
                    default:     v = $urandom_range(0, 255);
                endcase
            end
            gap = (i % 300 < 100) ? 0 : $urandom_range(0, 5);
            // first random access waits until the pipe has fully drained
            push_access(k, c, v, gap, i == 0);
        end
        total_items = pending_accesses.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (result_count < total_items)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("accesses sent %0d, results checked %0d", sent_count, result_count);
        $display("sets applied %0d, sets rejected %0d, counts past the century %0d",
                 applied_count, rejected_count, wrapped_count);
        if (error_count == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/scc_pkg.sv
sv/scc_split.sv
sv/scc_decode.sv
sv/scc_compose.sv
sv/seconds_counter_calendar_convert_top.sv
dv/tb_top.sv
